FILE: hw/rtl/ssw_pkg.sv
// Shared types and constants for the structure table walker.
`default_nettype none

package ssw_pkg;

    // Walk phases
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_FORMAT  = 2'd1;
    localparam logic [1:0] PH_STRINGS = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BROKEN    = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    // Register index (paddr[2])
    localparam logic REG_TABLE_LENGTH = 1'b0;
    localparam logic REG_STRUCT_LIMIT = 1'b1;

    // Header size in bytes
    localparam int HDR_SIZE = 4;

    // Result payload; first member is the most significant
    typedef struct packed {
        logic [15:0] structure_index;
        logic [15:0] total_size;
        logic [15:0] start_offset;
        logic [15:0] handle;
        logic [7:0]  structure_length;
        logic [7:0]  structure_type;
    } t_payload;

    // One result word with its sideband
    typedef struct packed {
        logic [1:0] status;
        logic       table_done;
        t_payload   data;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/smbios_structure_walker_core.sv
// Structure table walker: byte stream in, one word per structure out.
//
// Usage:
//   Input stream (i_s_*): one table byte per word in tdata[7:0]; tuser[0]
//   marks the first byte of a new table and restarts the walk at offset 0.
//   Output stream (o_m_*): one word per finished structure, per broken
//   header and per structure cut off by the end of the table. tuser holds
//   the status, tlast is set when nothing more comes for this table.
//   APB port: table_length at 0x0, structure_limit at 0x4; write only
//   while the walker is idle.
// Timing:
//   Each accepted byte is handled in its acceptance cycle; its result word
//   is registered in the output or skid register. One byte per cycle is
//   taken continuously; the only limit is the two-word output buffer.
// Stall:
//   An output register plus one skid register hold results while the
//   receiver stalls; o_s_tready drops only when both are occupied.
// Reset:
//   Synchronous, active low. Clears both registers, the walk state and
//   the output buffer; bytes before any first mark walk from offset 0.
`default_nettype none

module smbios_structure_walker_core
    import ssw_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] table_byte
    input  wire  [0:0]  i_s_tuser,   // [0] first
    // output stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [79:0] o_m_tdata,   // type, length, handle, start, size, index
    output logic [1:0]  o_m_tuser,   // [1:0] status
    output logic        o_m_tlast,   // table_done
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int OB = OFFSET_BITS;
    localparam int CW = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 2;

    // Configuration registers
    logic [15:0] r_table_length;
    logic [15:0] r_structure_limit;

    // Walk state
    logic [OB-1:0] r_byte_offset, n_byte_offset;
    logic [OB-1:0] r_struct_start, n_struct_start;
    logic [15:0]   r_seen, n_seen;
    logic [7:0]    r_held_type, n_held_type;
    logic [7:0]    r_held_len, n_held_len;
    logic [15:0]   r_held_handle, n_held_handle;
    logic          r_lbz, n_lbz;
    logic [1:0]    r_phase, n_phase;

    // Output buffer
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    logic    acc;
    logic    res_valid;
    t_result res;

    // Effective state after a first mark
    logic [OB-1:0] e_offset, e_start;
    logic [15:0]   e_seen;
    logic          e_lbz;
    logic [1:0]    e_phase;

    logic [OB-1:0] k;
    logic [CW-1:0] o_w, start_w, tl_w, next_w;
    logic [15:0]   seen_next;
    logic          at_last;
    logic          stopped;
    logic          ended;
    logic [7:0]    b;

    function automatic logic may_start(input logic [CW-1:0] start, input logic [15:0] seen,
                                       input logic [CW-1:0] tl, input logic [15:0] lim);
        begin
            may_start = (seen < lim) && ((start + CW'(HDR_SIZE)) <= tl);
        end
    endfunction

    // APB port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length    <= '0;
            r_structure_limit <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_TABLE_LENGTH: r_table_length    <= pwdata[15:0];
                REG_STRUCT_LIMIT: r_structure_limit <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TABLE_LENGTH: prdata = {16'd0, r_table_length};
            REG_STRUCT_LIMIT: prdata = {16'd0, r_structure_limit};
            default:          prdata = '0;
        endcase
    end

    // Handshake
    assign acc        = i_s_tvalid && o_s_tready;
    assign o_s_tready = !r_skid_valid;
    assign b          = i_s_tdata[7:0];

    // Per-byte walk logic
    always_comb begin
        if (i_s_tuser[0]) begin
            e_offset = '0;
            e_start  = '0;
            e_seen   = '0;
            e_lbz    = 1'b0;
            e_phase  = PH_HEADER;
        end else begin
            e_offset = r_byte_offset;
            e_start  = r_struct_start;
            e_seen   = r_seen;
            e_lbz    = r_lbz;
            e_phase  = r_phase;
        end

        k         = e_offset - e_start;
        o_w       = CW'(e_offset);
        start_w   = CW'(e_start);
        tl_w      = CW'(r_table_length);
        next_w    = o_w + CW'(1);
        seen_next = e_seen + 16'd1;
        at_last   = (r_table_length != 16'd0) && (o_w == tl_w - CW'(1));

        n_byte_offset  = (e_offset != {OB{1'b1}}) ? e_offset + OB'(1) : e_offset;
        n_struct_start = e_start;
        n_seen         = e_seen;
        n_held_type    = r_held_type;
        n_held_len     = r_held_len;
        n_held_handle  = r_held_handle;
        n_lbz          = e_lbz;
        n_phase        = e_phase;

        stopped   = 1'b0;
        ended     = 1'b0;
        res_valid = 1'b0;
        res       = '0;

        case (e_phase)
            PH_DONE: begin
                stopped = 1'b1;
            end
            PH_HEADER: begin
                if (k == '0) begin
                    if (!may_start(start_w, e_seen, tl_w, r_structure_limit)) begin
                        n_phase = PH_DONE;
                        stopped = 1'b1;
                    end else begin
                        n_held_type = b;
                    end
                end else if (k == OB'(1)) begin
                    n_held_len = b;
                end else if (k == OB'(2)) begin
                    n_held_handle = {8'd0, b};
                end else begin
                    n_held_handle = {b, r_held_handle[7:0]};
                    if (r_held_len < 8'(HDR_SIZE)) begin
                        // broken header: report and stop
                        res_valid  = 1'b1;
                        res.status = ST_BROKEN;
                        res.table_done = 1'b1;
                        res.data.total_size = '0;
                        n_phase = PH_DONE;
                        stopped = 1'b1;
                    end else begin
                        n_lbz   = 1'b0;
                        n_phase = (r_held_len == 8'(HDR_SIZE)) ? PH_STRINGS : PH_FORMAT;
                    end
                end
            end
            PH_FORMAT: begin
                if (({1'b0, k} + (OB+1)'(1)) >= (OB+1)'(r_held_len)) begin
                    n_lbz   = 1'b0;
                    n_phase = PH_STRINGS;
                end
            end
            default: begin
                // string area: look for the double zero
                if (b == 8'd0 && e_lbz) begin
                    ended = 1'b1;
                end else begin
                    n_lbz = (b == 8'd0);
                end
            end
        endcase

        if (!stopped) begin
            if (ended) begin
                res_valid = 1'b1;
                res.status = ST_OK;
                res.table_done = !may_start(next_w, seen_next, tl_w, r_structure_limit);
                res.data.total_size = 16'(next_w - start_w);
                n_seen         = seen_next;
                n_struct_start = next_w[OB-1:0];
                n_lbz          = 1'b0;
                n_phase        = res.table_done ? PH_DONE : PH_HEADER;
            end else if (at_last) begin
                res_valid = 1'b1;
                res.status = ST_TRUNCATED;
                res.table_done = 1'b1;
                res.data.total_size = 16'(tl_w - start_w);
                n_phase = PH_DONE;
            end
        end

        // fields common to every result
        res.data.structure_type   = n_held_type;
        res.data.structure_length = n_held_len;
        res.data.handle           = n_held_handle;
        res.data.start_offset     = start_w[15:0];
        res.data.structure_index  = e_seen;
    end

    // Walk state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset  <= '0;
            r_struct_start <= '0;
            r_seen         <= '0;
            r_held_type    <= '0;
            r_held_len     <= '0;
            r_held_handle  <= '0;
            r_lbz          <= 1'b0;
            r_phase        <= PH_HEADER;
        end else if (acc) begin
            r_byte_offset  <= n_byte_offset;
            r_struct_start <= n_struct_start;
            r_seen         <= n_seen;
            r_held_type    <= n_held_type;
            r_held_len     <= n_held_len;
            r_held_handle  <= n_held_handle;
            r_lbz          <= n_lbz;
            r_phase        <= n_phase;
        end
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= acc && res_valid;
            end
        end else if (acc && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (acc && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.data;
    assign o_m_tuser  = r_out.status;
    assign o_m_tlast  = r_out.table_done;

endmodule

`default_nettype wire

FILE: hw/rtl/ssw_checker.sv
// Port-level checks for the structure table walker, bound to smbios_structure_walker_core.
`default_nettype none

module ssw_checker
    import ssw_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [79:0] o_m_tdata,
    input wire [1:0]  o_m_tuser,
    input wire        o_m_tlast
);

    // a stalled word stays valid
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output word dropped while stalled");

    // no word in the cycle after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // only defined status codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == ST_OK || o_m_tuser == ST_BROKEN ||
                        o_m_tuser == ST_TRUNCATED))
        else $error("undefined status code");

    // broken or truncated always ends the table
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_OK |-> o_m_tlast)
        else $error("error status without table end");

    // a broken header reports no size
    a_broken_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_BROKEN |-> o_m_tdata[63:48] == 16'd0)
        else $error("broken header with nonzero size");

endmodule

bind smbios_structure_walker_core ssw_checker u_ssw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
